// ===== hdl/assert_macros.svh =====
// assertion macros used by the sequencer core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CHK_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/tacs_pkg.sv =====
// types and constants of the twin arm cycle sequencer
package tacs_pkg;

    localparam int unsigned SENSOR_FILTER_LEN  = 10;
    localparam int unsigned SWITCH_FILTER_LEN  = 30;
    localparam int unsigned BUTTON_PRESS_TICKS = 3;
    localparam int unsigned SWITCH_ON_AT       = (SWITCH_FILTER_LEN * 5) / 6;
    localparam int unsigned SWITCH_OFF_AT      = SWITCH_FILTER_LEN / 6;
    localparam int unsigned READY_LEN          = 10;
    localparam int unsigned READY_ON_AT        = 9;
    localparam int unsigned READY_OFF_AT       = 1;

    localparam int unsigned SNS_CNT_W = $clog2(SENSOR_FILTER_LEN + 1);
    localparam int unsigned SW_CNT_W  = $clog2(SWITCH_FILTER_LEN + 1);
    localparam int unsigned RDY_CNT_W = $clog2(READY_LEN + 1);
    localparam int unsigned BTN_CNT_W = $clog2(BUTTON_PRESS_TICKS + 1);
    localparam int unsigned DELAY_W   = 7;
    localparam int unsigned NUM_CFG   = 7;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [SNS_CNT_W-1:0] SNS_TOP    = SNS_CNT_W'(SENSOR_FILTER_LEN);
    localparam logic [SW_CNT_W-1:0]  SW_TOP     = SW_CNT_W'(SWITCH_FILTER_LEN);
    localparam logic [SW_CNT_W-1:0]  SW_ON      = SW_CNT_W'(SWITCH_ON_AT);
    localparam logic [SW_CNT_W-1:0]  SW_OFF     = SW_CNT_W'(SWITCH_OFF_AT);
    localparam logic [RDY_CNT_W-1:0] RDY_TOP    = RDY_CNT_W'(READY_LEN);
    localparam logic [RDY_CNT_W-1:0] RDY_ON     = RDY_CNT_W'(READY_ON_AT);
    localparam logic [RDY_CNT_W-1:0] RDY_OFF    = RDY_CNT_W'(READY_OFF_AT);
    localparam logic [BTN_CNT_W-1:0] BTN_TOP    = BTN_CNT_W'(BUTTON_PRESS_TICKS);

    // sensor order: main magnet, arm1 magnet, arm2 magnet, vac1, vac2
    localparam int unsigned NUM_SENSORS = 5;
    localparam int unsigned SNS_MAIN_MAG = 0;
    localparam int unsigned SNS_ARM1_MAG = 1;
    localparam int unsigned SNS_ARM2_MAG = 2;
    localparam int unsigned SNS_VAC1     = 3;
    localparam int unsigned SNS_VAC2     = 4;
    localparam logic [3:0] SENSOR_BIT [NUM_SENSORS] = '{4'd13, 4'd0, 4'd15, 4'd2, 4'd14};

    // switch order: arm1, arm2, loop
    localparam int unsigned NUM_SWITCHES = 3;
    localparam int unsigned SW_ARM1 = 0;
    localparam int unsigned SW_ARM2 = 1;
    localparam int unsigned SW_LOOP = 2;
    localparam logic [3:0] SWITCH_BIT [NUM_SWITCHES] = '{4'd9, 4'd8, 4'd10};

    // ready order: arm1 on bit1, arm2 on bit0
    localparam int unsigned NUM_READY = 2;
    localparam logic READY_BIT [NUM_READY] = '{1'b1, 1'b0};

    // buttons: start, stop
    localparam int unsigned NUM_BUTTONS = 2;
    localparam int unsigned BTN_START = 0;
    localparam int unsigned BTN_STOP  = 1;
    localparam logic [3:0] BUTTON_BIT [NUM_BUTTONS] = '{4'd6, 4'd5};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAIN_DELAY,
        CFG_ARM_WAIT,
        CFG_ARM_PRESS,
        CFG_ARM_HOLD_A,
        CFG_ARM_HOLD_B,
        CFG_ARM_RELEASE,
        CFG_ARM_TAIL
    } t_cfg_idx;

    localparam logic [DELAY_W-1:0] CFG_RESET [NUM_CFG] =
        '{7'd30, 7'd20, 7'd20, 7'd50, 7'd80, 7'd60, 7'd20};

    typedef enum logic [2:0] {
        MAIN_OFF,
        MAIN_READY,
        MAIN_OPEN1,
        MAIN_MAGNET,
        MAIN_OPEN2,
        MAIN_LAUNCH,
        MAIN_WAIT
    } t_main_step;

    typedef enum logic [3:0] {
        ARM_OFF,
        ARM_LOAD,
        ARM_IDLE,
        ARM_PRESS,
        ARM_VAC,
        ARM_HOLD_A,
        ARM_HOLD_B,
        ARM_RELEASE,
        ARM_TAIL,
        ARM_DONE
    } t_arm_step;

    typedef struct packed {
        logic [15:0] lines_n;
        logic [1:0]  ready_n;
    } t_in_item;

    typedef struct packed {
        logic [1:0] main_valves;
        logic [3:0] arm1_valves;
        logic [3:0] arm2_valves;
        logic       work_led;
        logic       alarm_led;
        logic [2:0] main_step;
        logic [3:0] arm1_step;
        logic [3:0] arm2_step;
    } t_out_item;

    typedef struct packed {
        logic advance;
        logic launch;
        logic hold_off;
        logic stop;
    } t_arm_ctl;

    typedef struct packed {
        logic [DELAY_W-1:0] wait_len;
        logic [DELAY_W-1:0] press_len;
        logic [DELAY_W-1:0] hold_a_len;
        logic [DELAY_W-1:0] hold_b_len;
        logic [DELAY_W-1:0] rel_len;
        logic [DELAY_W-1:0] tail_len;
    } t_arm_timing;

    typedef struct packed {
        t_arm_step  phase;
        t_arm_step  phase_next;
        logic [3:0] valves;
    } t_arm_stat;

endpackage

// ===== hdl/tacs_arm.sv =====
// one arm valve sequencer with its phase and delay counter
module tacs_arm (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tacs_pkg::t_arm_ctl    i_ctl,
    input  tacs_pkg::t_arm_timing i_timing,
    input  logic                  i_vac,
    input  logic                  i_magnet,
    output tacs_pkg::t_arm_stat   o_stat
);

    tacs_pkg::t_arm_step r_phase;
    tacs_pkg::t_arm_step n_phase;
    tacs_pkg::t_arm_step w_cur;
    logic [tacs_pkg::DELAY_W-1:0] r_count;
    logic [tacs_pkg::DELAY_W-1:0] n_count;
    logic [tacs_pkg::DELAY_W-1:0] w_dec;
    logic                         w_zero;
    logic [3:0]                   w_valves;

    always_comb begin
        if (i_ctl.hold_off) begin
            w_cur = tacs_pkg::ARM_OFF;
        end else if (i_ctl.launch) begin
            w_cur = tacs_pkg::ARM_LOAD;
        end else begin
            w_cur = r_phase;
        end
    end

    assign w_dec  = r_count - tacs_pkg::DELAY_W'(1);
    assign w_zero = (w_dec == '0);

    always_comb begin
        n_phase = w_cur;
        n_count = r_count;
        unique case (w_cur)
            tacs_pkg::ARM_LOAD: begin
                n_count = i_timing.wait_len;
                n_phase = tacs_pkg::ARM_IDLE;
            end
            tacs_pkg::ARM_IDLE: begin
                n_count = w_dec;
                if (w_zero) begin
                    n_count = i_timing.press_len;
                    n_phase = tacs_pkg::ARM_PRESS;
                end
            end
            tacs_pkg::ARM_PRESS: begin
                n_count = w_dec;
                if (w_zero) begin
                    n_phase = tacs_pkg::ARM_VAC;
                end
            end
            tacs_pkg::ARM_VAC: begin
                if (i_vac) begin
                    n_count = i_timing.hold_a_len;
                    n_phase = tacs_pkg::ARM_HOLD_A;
                end
            end
            tacs_pkg::ARM_HOLD_A: begin
                n_count = w_dec;
                if (w_zero) begin
                    n_count = i_timing.hold_b_len;
                    n_phase = tacs_pkg::ARM_HOLD_B;
                end
            end
            tacs_pkg::ARM_HOLD_B: begin
                n_count = w_dec;
                if (w_zero) begin
                    n_count = i_timing.rel_len;
                    n_phase = tacs_pkg::ARM_RELEASE;
                end
            end
            tacs_pkg::ARM_RELEASE: begin
                n_count = w_dec;
                if (w_zero) begin
                    n_count = i_timing.tail_len;
                    n_phase = tacs_pkg::ARM_TAIL;
                end
            end
            tacs_pkg::ARM_TAIL: begin
                n_count = w_dec;
                if (w_zero) begin
                    n_phase = tacs_pkg::ARM_DONE;
                end
            end
            tacs_pkg::ARM_DONE: begin
                if (i_magnet) begin
                    n_phase = tacs_pkg::ARM_OFF;
                end
            end
            default: begin
                n_phase = tacs_pkg::ARM_OFF;
            end
        endcase
    end

    always_comb begin
        unique case (w_cur)
            tacs_pkg::ARM_PRESS:   w_valves = 4'h1;
            tacs_pkg::ARM_VAC:     w_valves = 4'h3;
            tacs_pkg::ARM_HOLD_A:  w_valves = 4'h7;
            tacs_pkg::ARM_HOLD_B:  w_valves = 4'hf;
            tacs_pkg::ARM_RELEASE: w_valves = 4'h9;
            tacs_pkg::ARM_TAIL:    w_valves = 4'h8;
            default:               w_valves = 4'h0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= tacs_pkg::ARM_OFF;
            r_count <= '0;
        end else if (i_ctl.advance) begin
            r_phase <= i_ctl.stop ? tacs_pkg::ARM_OFF : n_phase;
            r_count <= n_count;
        end
    end

    assign o_stat.phase      = r_phase;
    assign o_stat.phase_next = n_phase;
    assign o_stat.valves     = w_valves;

endmodule

// ===== hdl/twin_arm_cycle_sequencer_core.sv =====
// top level of the twin arm cycle sequencer: filters, main sequencer and result register
//
//  channel  | signals                                   | carries
//  ---------+-------------------------------------------+---------------------------
//  in       | i_in_valid, o_in_ready, i_in_data         | one tick of lines and ready
//  out      | o_out_valid, i_out_ready, o_out_data      | valves, leds and steps
//  cfg      | i_cfg_we, i_cfg_idx, i_cfg_data           | timing register write
//
// one item per clock unless out stalls; a tick goes in one pass to the result register
// the result appears in the cycle after the item is accepted
// a waiting result is replaced in the same cycle it is taken, so a stall on out
// holds off in for exactly as long as the result is not taken
// synchronous active-low reset restores the timing registers and resets all filters
`include "assert_macros.svh"

module twin_arm_cycle_sequencer_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  tacs_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output tacs_pkg::t_out_item                 o_out_data,
    input  logic                                i_cfg_we,
    input  logic [tacs_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tacs_pkg::DELAY_W-1:0]        i_cfg_data
);

    logic [tacs_pkg::DELAY_W-1:0]   r_cfg [tacs_pkg::NUM_CFG];

    logic [tacs_pkg::SNS_CNT_W-1:0] r_sns_cnt  [tacs_pkg::NUM_SENSORS];
    logic [tacs_pkg::SNS_CNT_W-1:0] n_sns_cnt  [tacs_pkg::NUM_SENSORS];
    logic                           r_sns_flag [tacs_pkg::NUM_SENSORS];
    logic                           n_sns_flag [tacs_pkg::NUM_SENSORS];
    logic [tacs_pkg::SW_CNT_W-1:0]  r_sw_cnt   [tacs_pkg::NUM_SWITCHES];
    logic [tacs_pkg::SW_CNT_W-1:0]  n_sw_cnt   [tacs_pkg::NUM_SWITCHES];
    logic                           r_sw_flag  [tacs_pkg::NUM_SWITCHES];
    logic                           n_sw_flag  [tacs_pkg::NUM_SWITCHES];
    logic [tacs_pkg::RDY_CNT_W-1:0] r_rdy_cnt  [tacs_pkg::NUM_READY];
    logic [tacs_pkg::RDY_CNT_W-1:0] n_rdy_cnt  [tacs_pkg::NUM_READY];
    logic                           r_rdy_flag [tacs_pkg::NUM_READY];
    logic                           n_rdy_flag [tacs_pkg::NUM_READY];
    logic [tacs_pkg::BTN_CNT_W-1:0] r_btn_cnt  [tacs_pkg::NUM_BUTTONS];
    logic [tacs_pkg::BTN_CNT_W-1:0] n_btn_cnt  [tacs_pkg::NUM_BUTTONS];
    logic                           w_press    [tacs_pkg::NUM_BUTTONS];

    tacs_pkg::t_main_step           r_main;
    tacs_pkg::t_main_step           n_main;
    tacs_pkg::t_main_step           w_main_mid;
    logic [tacs_pkg::DELAY_W-1:0]   r_main_cnt;
    logic [tacs_pkg::DELAY_W-1:0]   n_main_cnt;
    logic [tacs_pkg::DELAY_W-1:0]   w_main_dec;
    logic [1:0]                     w_main_valves;

    tacs_pkg::t_arm_ctl             w_arm1_ctl;
    tacs_pkg::t_arm_ctl             w_arm2_ctl;
    tacs_pkg::t_arm_timing          w_timing;
    tacs_pkg::t_arm_stat            w_arm1;
    tacs_pkg::t_arm_stat            w_arm2;
    tacs_pkg::t_arm_step            w_arm1_final;
    tacs_pkg::t_arm_step            w_arm2_final;

    logic                           w_in_acc;
    logic                           w_start;
    logic                           w_stop;
    tacs_pkg::t_out_item            w_out;
    tacs_pkg::t_out_item            r_out;
    logic                           r_out_valid;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_in_acc   = i_in_valid && o_in_ready;

    // timing registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= tacs_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (tacs_pkg::t_cfg_idx'(i_cfg_idx))
                tacs_pkg::CFG_MAIN_DELAY,
                tacs_pkg::CFG_ARM_WAIT,
                tacs_pkg::CFG_ARM_PRESS,
                tacs_pkg::CFG_ARM_HOLD_A,
                tacs_pkg::CFG_ARM_HOLD_B,
                tacs_pkg::CFG_ARM_RELEASE,
                tacs_pkg::CFG_ARM_TAIL: r_cfg[i_cfg_idx] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_timing.wait_len   = r_cfg[tacs_pkg::CFG_ARM_WAIT];
    assign w_timing.press_len  = r_cfg[tacs_pkg::CFG_ARM_PRESS];
    assign w_timing.hold_a_len = r_cfg[tacs_pkg::CFG_ARM_HOLD_A];
    assign w_timing.hold_b_len = r_cfg[tacs_pkg::CFG_ARM_HOLD_B];
    assign w_timing.rel_len    = r_cfg[tacs_pkg::CFG_ARM_RELEASE];
    assign w_timing.tail_len   = r_cfg[tacs_pkg::CFG_ARM_TAIL];

    // sensor debouncers
    always_comb begin
        for (int i = 0; i < tacs_pkg::NUM_SENSORS; i++) begin
            n_sns_cnt[i]  = r_sns_cnt[i];
            n_sns_flag[i] = r_sns_flag[i];
            if (!i_in_data.lines_n[tacs_pkg::SENSOR_BIT[i]]) begin
                if (r_sns_cnt[i] < tacs_pkg::SNS_TOP) begin
                    n_sns_cnt[i] = r_sns_cnt[i] + tacs_pkg::SNS_CNT_W'(1);
                    if (n_sns_cnt[i] == tacs_pkg::SNS_TOP) begin
                        n_sns_flag[i] = 1'b1;
                    end
                end
            end else if (r_sns_cnt[i] != '0) begin
                n_sns_cnt[i] = r_sns_cnt[i] - tacs_pkg::SNS_CNT_W'(1);
                if (n_sns_cnt[i] == '0) begin
                    n_sns_flag[i] = 1'b0;
                end
            end
        end
    end

    // main sequencer
    assign w_main_dec = r_main_cnt - tacs_pkg::DELAY_W'(1);

    always_comb begin
        w_main_mid = r_main;
        n_main_cnt = r_main_cnt;
        unique case (r_main)
            tacs_pkg::MAIN_READY: begin
                if ((r_rdy_flag[0] || !r_sw_flag[tacs_pkg::SW_ARM1]) &&
                    (r_rdy_flag[1] || !r_sw_flag[tacs_pkg::SW_ARM2])) begin
                    w_main_mid = tacs_pkg::MAIN_OPEN1;
                    n_main_cnt = r_cfg[tacs_pkg::CFG_MAIN_DELAY];
                end
            end
            tacs_pkg::MAIN_OPEN1: begin
                n_main_cnt = w_main_dec;
                if (w_main_dec == '0) begin
                    w_main_mid = tacs_pkg::MAIN_MAGNET;
                end
            end
            tacs_pkg::MAIN_MAGNET: begin
                if (n_sns_flag[tacs_pkg::SNS_MAIN_MAG]) begin
                    w_main_mid = tacs_pkg::MAIN_OPEN2;
                    n_main_cnt = r_cfg[tacs_pkg::CFG_MAIN_DELAY];
                end
            end
            tacs_pkg::MAIN_OPEN2: begin
                n_main_cnt = w_main_dec;
                if (w_main_dec == '0) begin
                    w_main_mid = tacs_pkg::MAIN_LAUNCH;
                end
            end
            tacs_pkg::MAIN_LAUNCH: begin
                w_main_mid = tacs_pkg::MAIN_WAIT;
            end
            tacs_pkg::MAIN_WAIT: begin
                if ((w_arm1.phase == tacs_pkg::ARM_OFF || !r_sw_flag[tacs_pkg::SW_ARM1]) &&
                    (w_arm2.phase == tacs_pkg::ARM_OFF || !r_sw_flag[tacs_pkg::SW_ARM2])) begin
                    w_main_mid = r_sw_flag[tacs_pkg::SW_LOOP] ? tacs_pkg::MAIN_READY
                                                              : tacs_pkg::MAIN_OFF;
                end
            end
            default: begin
                w_main_mid = tacs_pkg::MAIN_OFF;
            end
        endcase
    end

    always_comb begin
        unique case (r_main)
            tacs_pkg::MAIN_OPEN1:  w_main_valves = 2'b01;
            tacs_pkg::MAIN_MAGNET: w_main_valves = 2'b11;
            tacs_pkg::MAIN_OPEN2:  w_main_valves = 2'b10;
            default:               w_main_valves = 2'b00;
        endcase
    end

    // arm sequencers
    always_comb begin
        w_arm1_ctl.advance  = w_in_acc;
        w_arm1_ctl.launch   = (r_main == tacs_pkg::MAIN_LAUNCH) && r_sw_flag[tacs_pkg::SW_ARM1];
        w_arm1_ctl.hold_off = (w_main_mid == tacs_pkg::MAIN_OFF) || !r_sw_flag[tacs_pkg::SW_ARM1];
        w_arm1_ctl.stop     = w_stop;
        w_arm2_ctl.advance  = w_in_acc;
        w_arm2_ctl.launch   = (r_main == tacs_pkg::MAIN_LAUNCH) && r_sw_flag[tacs_pkg::SW_ARM2];
        w_arm2_ctl.hold_off = (w_main_mid == tacs_pkg::MAIN_OFF) || !r_sw_flag[tacs_pkg::SW_ARM2];
        w_arm2_ctl.stop     = w_stop;
    end

    tacs_arm u_arm1 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_arm1_ctl),
        .i_timing (w_timing),
        .i_vac    (n_sns_flag[tacs_pkg::SNS_VAC1]),
        .i_magnet (n_sns_flag[tacs_pkg::SNS_ARM1_MAG]),
        .o_stat   (w_arm1)
    );

    tacs_arm u_arm2 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_arm2_ctl),
        .i_timing (w_timing),
        .i_vac    (n_sns_flag[tacs_pkg::SNS_VAC2]),
        .i_magnet (n_sns_flag[tacs_pkg::SNS_ARM2_MAG]),
        .o_stat   (w_arm2)
    );

    // start and stop buttons
    always_comb begin
        for (int i = 0; i < tacs_pkg::NUM_BUTTONS; i++) begin
            n_btn_cnt[i] = r_btn_cnt[i];
            w_press[i]   = 1'b0;
            if (i_in_data.lines_n[tacs_pkg::BUTTON_BIT[i]]) begin
                n_btn_cnt[i] = '0;
            end else if (r_btn_cnt[i] < tacs_pkg::BTN_TOP) begin
                n_btn_cnt[i] = r_btn_cnt[i] + tacs_pkg::BTN_CNT_W'(1);
                w_press[i]   = (n_btn_cnt[i] == tacs_pkg::BTN_TOP);
            end
        end
    end

    assign w_start = w_press[tacs_pkg::BTN_START];
    assign w_stop  = w_press[tacs_pkg::BTN_STOP];

    always_comb begin
        n_main = w_main_mid;
        if (w_start && w_main_mid == tacs_pkg::MAIN_OFF &&
            w_arm1.phase_next == tacs_pkg::ARM_OFF &&
            w_arm2.phase_next == tacs_pkg::ARM_OFF) begin
            n_main = tacs_pkg::MAIN_READY;
        end
        if (w_stop) begin
            n_main = tacs_pkg::MAIN_OFF;
        end
    end

    assign w_arm1_final = w_stop ? tacs_pkg::ARM_OFF : w_arm1.phase_next;
    assign w_arm2_final = w_stop ? tacs_pkg::ARM_OFF : w_arm2.phase_next;

    // switch filters with hysteresis
    always_comb begin
        for (int i = 0; i < tacs_pkg::NUM_SWITCHES; i++) begin
            n_sw_cnt[i] = r_sw_cnt[i];
            if (!i_in_data.lines_n[tacs_pkg::SWITCH_BIT[i]]) begin
                if (r_sw_cnt[i] < tacs_pkg::SW_TOP) begin
                    n_sw_cnt[i] = r_sw_cnt[i] + tacs_pkg::SW_CNT_W'(1);
                end
            end else if (r_sw_cnt[i] != '0) begin
                n_sw_cnt[i] = r_sw_cnt[i] - tacs_pkg::SW_CNT_W'(1);
            end
            if (n_sw_cnt[i] >= tacs_pkg::SW_ON) begin
                n_sw_flag[i] = 1'b1;
            end else if (n_sw_cnt[i] <= tacs_pkg::SW_OFF) begin
                n_sw_flag[i] = 1'b0;
            end else begin
                n_sw_flag[i] = r_sw_flag[i];
            end
        end
    end

    // ready filters
    always_comb begin
        for (int i = 0; i < tacs_pkg::NUM_READY; i++) begin
            n_rdy_cnt[i] = r_rdy_cnt[i];
            if (!i_in_data.ready_n[tacs_pkg::READY_BIT[i]]) begin
                if (r_rdy_cnt[i] < tacs_pkg::RDY_TOP) begin
                    n_rdy_cnt[i] = r_rdy_cnt[i] + tacs_pkg::RDY_CNT_W'(1);
                end
            end else if (r_rdy_cnt[i] != '0) begin
                n_rdy_cnt[i] = r_rdy_cnt[i] - tacs_pkg::RDY_CNT_W'(1);
            end
            if (n_rdy_cnt[i] >= tacs_pkg::RDY_ON) begin
                n_rdy_flag[i] = 1'b1;
            end else if (n_rdy_cnt[i] <= tacs_pkg::RDY_OFF) begin
                n_rdy_flag[i] = 1'b0;
            end else begin
                n_rdy_flag[i] = r_rdy_flag[i];
            end
        end
    end

    // result item
    always_comb begin
        w_out.main_valves = w_main_valves;
        w_out.arm1_valves = w_arm1.valves;
        w_out.arm2_valves = w_arm2.valves;
        w_out.work_led    = (n_main == tacs_pkg::MAIN_OFF) &&
                            (w_arm1_final == tacs_pkg::ARM_OFF) &&
                            (w_arm2_final == tacs_pkg::ARM_OFF);
        w_out.alarm_led   = ((n_main == tacs_pkg::MAIN_OFF) &&
                             n_sns_flag[tacs_pkg::SNS_MAIN_MAG]) ||
                            (n_sw_flag[tacs_pkg::SW_ARM1] &&
                             (w_arm1_final == tacs_pkg::ARM_OFF) &&
                             (n_sns_flag[tacs_pkg::SNS_ARM1_MAG] ||
                              n_sns_flag[tacs_pkg::SNS_VAC1])) ||
                            (n_sw_flag[tacs_pkg::SW_ARM2] &&
                             (w_arm2_final == tacs_pkg::ARM_OFF) &&
                             (n_sns_flag[tacs_pkg::SNS_ARM2_MAG] ||
                              n_sns_flag[tacs_pkg::SNS_VAC2]));
        w_out.main_step   = n_main;
        w_out.arm1_step   = w_arm1_final;
        w_out.arm2_step   = w_arm2_final;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < tacs_pkg::NUM_SENSORS; i++) begin
                r_sns_cnt[i]  <= '0;
                r_sns_flag[i] <= 1'b0;
            end
            for (int i = 0; i < tacs_pkg::NUM_SWITCHES; i++) begin
                r_sw_cnt[i]  <= '0;
                r_sw_flag[i] <= 1'b1;
            end
            for (int i = 0; i < tacs_pkg::NUM_READY; i++) begin
                r_rdy_cnt[i]  <= '0;
                r_rdy_flag[i] <= 1'b1;
            end
            for (int i = 0; i < tacs_pkg::NUM_BUTTONS; i++) begin
                r_btn_cnt[i] <= '0;
            end
            r_main      <= tacs_pkg::MAIN_OFF;
            r_main_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_sns_cnt   <= n_sns_cnt;
                r_sns_flag  <= n_sns_flag;
                r_sw_cnt    <= n_sw_cnt;
                r_sw_flag   <= n_sw_flag;
                r_rdy_cnt   <= n_rdy_cnt;
                r_rdy_flag  <= n_rdy_flag;
                r_btn_cnt   <= n_btn_cnt;
                r_main      <= n_main;
                r_main_cnt  <= n_main_cnt;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_out <= w_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `CHK_NXT(a_acc_gives_item, w_in_acc, o_out_valid, "accepted item gave no result")
    `CHK_NXT(a_stop_clears, w_in_acc && w_stop, r_main == tacs_pkg::MAIN_OFF && w_arm1.phase == tacs_pkg::ARM_OFF && w_arm2.phase == tacs_pkg::ARM_OFF, "stop left a sequencer running")
    `CHK_IMP(a_arm1_in_wait, w_arm1.phase != tacs_pkg::ARM_OFF, r_main == tacs_pkg::MAIN_WAIT, "arm one active outside main wait")
    `CHK_IMP(a_arm2_in_wait, w_arm2.phase != tacs_pkg::ARM_OFF, r_main == tacs_pkg::MAIN_WAIT, "arm two active outside main wait")

endmodule
